### src/ehe_pkg.sv
// shared types and constants for the echo hiding embedder
// used by ehe_front, ehe_queue, ehe_back and echo_hiding_embedder_top
package ehe_pkg;

  localparam int HDR_LEN_DEF     = 128;
  localparam int DELAY_DEPTH_DEF = 1024;

  localparam int SAMPLE_W  = 16;
  localparam int BLOCK_W   = 16;
  localparam int DELAY_W   = 10;
  localparam int GAIN_W    = 15;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DAT_W = 16;

  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QLVL_W      = $clog2(QUEUE_DEPTH + 1);

  localparam logic [BLOCK_W-1:0] BLOCK_SIZE_RST = 16'd1024;
  localparam logic [DELAY_W-1:0] DELAY_ZERO_RST = 10'd50;
  localparam logic [DELAY_W-1:0] DELAY_ONE_RST  = 10'd100;
  localparam logic [GAIN_W-1:0]  GAIN_RST       = 15'd16384;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_HDR_BLOCK_SIZE,
    CFG_HDR_DELAY_ZERO,
    CFG_HDR_DELAY_ONE,
    CFG_HDR_GAIN,
    CFG_BLOCK_SIZE,
    CFG_DELAY_ZERO,
    CFG_DELAY_ONE,
    CFG_GAIN
  } cfg_reg_e;

  // one classified sample on its way to the arithmetic
  typedef struct packed {
    logic [SAMPLE_W-1:0] sample;
    logic [GAIN_W-1:0]   alpha;
    logic                active;
    logic [SAMPLE_W-1:0] tap_p;
    logic [SAMPLE_W-1:0] tap_n;
  } ehe_item_t;

endpackage

### src/ehe_front.sv
// front end: config registers, block and bit tracking, delay line and tap reads
// depends on ehe_pkg
module ehe_front import ehe_pkg::*; #(
  parameter int HDR_LEN     = HDR_LEN_DEF,
  parameter int DELAY_DEPTH = DELAY_DEPTH_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_valid_i,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [CFG_DAT_W-1:0] cfg_data_i,
  input  logic                 in_valid_i,
  input  logic [SAMPLE_W-1:0]  sample_i,
  input  logic                 message_bit_i,
  input  logic                 message_more_i,
  output logic                 in_stall_o,
  input  logic [QLVL_W-1:0]    q_level_i,
  output logic                 push_o,
  output ehe_item_t            item_o
);

  localparam int AW     = $clog2(DELAY_DEPTH);
  localparam int CNT_W  = $clog2(DELAY_DEPTH + 1);
  localparam int W      = (AW + 1 > DELAY_W) ? AW + 1 : DELAY_W;
  localparam int BD_W   = (HDR_LEN < 1) ? 1 : $clog2(HDR_LEN + 1);
  localparam int LVL1_W = QLVL_W + 1;

  // configuration registers
  logic [BLOCK_W-1:0] hbs_q, bs_q;
  logic [DELAY_W-1:0] hd0_q, hd1_q, d0_q, d1_q;
  logic [GAIN_W-1:0]  hg_q, g_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hbs_q <= BLOCK_SIZE_RST;
      hd0_q <= DELAY_ZERO_RST;
      hd1_q <= DELAY_ONE_RST;
      hg_q  <= GAIN_RST;
      bs_q  <= BLOCK_SIZE_RST;
      d0_q  <= DELAY_ZERO_RST;
      d1_q  <= DELAY_ONE_RST;
      g_q   <= GAIN_RST;
    end else if (cfg_valid_i) begin
      case (cfg_reg_e'(cfg_index_i))
        CFG_HDR_BLOCK_SIZE: hbs_q <= cfg_data_i[BLOCK_W-1:0];
        CFG_HDR_DELAY_ZERO: hd0_q <= cfg_data_i[DELAY_W-1:0];
        CFG_HDR_DELAY_ONE:  hd1_q <= cfg_data_i[DELAY_W-1:0];
        CFG_HDR_GAIN:       hg_q  <= cfg_data_i[GAIN_W-1:0];
        CFG_BLOCK_SIZE:     bs_q  <= cfg_data_i[BLOCK_W-1:0];
        CFG_DELAY_ZERO:     d0_q  <= cfg_data_i[DELAY_W-1:0];
        CFG_DELAY_ONE:      d1_q  <= cfg_data_i[DELAY_W-1:0];
        CFG_GAIN:           g_q   <= cfg_data_i[GAIN_W-1:0];
        default: ;
      endcase
    end
  end

  // control state
  logic [AW-1:0]      wp_q, wp_d;
  logic [CNT_W-1:0]   fill_q, fill_d;
  logic [BLOCK_W-1:0] bpos_q, bpos_d;
  logic [BD_W-1:0]    bits_done_q, bits_done_d;
  logic               cur_bit_q, cur_bit_d;
  logic               fin_q, fin_d;
  logic               s1_valid_q;

  logic               accept;
  logic [LVL1_W-1:0]  lvl_sum;
  logic               start, bit_now, fin_now, hdr;
  logic [BLOCK_W-1:0] sz, np;
  logic [DELAY_W-1:0] dsel0, dsel1, dp, dn;
  logic [GAIN_W-1:0]  alpha;
  logic [W-1:0]       dpc, dnc;
  logic [AW-1:0]      addr_p, addr_n;
  logic               pz, pv, nz, nv;

  function automatic logic [W-1:0] clamp_delay(logic [DELAY_W-1:0] d);
    logic [W-1:0] de;
    de = W'(d);
    return (de > W'(DELAY_DEPTH)) ? W'(DELAY_DEPTH) : de;
  endfunction

  function automatic logic [AW-1:0] tap_addr(logic [AW-1:0] wp, logic [W-1:0] dc);
    logic [W-1:0] s;
    s = W'(wp) + W'(DELAY_DEPTH) - dc;
    if (s >= W'(DELAY_DEPTH)) begin
      s = s - W'(DELAY_DEPTH);
    end
    return s[AW-1:0];
  endfunction

  // one slot held back for the item sitting in the read stage
  assign lvl_sum    = LVL1_W'(q_level_i) + LVL1_W'(s1_valid_q);
  assign in_stall_o = lvl_sum >= LVL1_W'(QUEUE_DEPTH);
  assign accept     = in_valid_i && !in_stall_o;

  always_comb begin
    start   = !fin_q && (bpos_q == '0);
    bit_now = (start && message_more_i) ? message_bit_i : cur_bit_q;
    fin_now = fin_q || (start && !message_more_i);
    hdr     = bits_done_q < BD_W'(HDR_LEN);
    sz      = hdr ? hbs_q : bs_q;
    dsel0   = hdr ? hd0_q : d0_q;
    dsel1   = hdr ? hd1_q : d1_q;
    alpha   = hdr ? hg_q : g_q;
    dp      = bit_now ? dsel1 : dsel0;
    dn      = bit_now ? dsel0 : dsel1;
    dpc     = clamp_delay(dp);
    dnc     = clamp_delay(dn);
    addr_p  = tap_addr(wp_q, dpc);
    addr_n  = tap_addr(wp_q, dnc);
    pz      = (dp == '0);
    nz      = (dn == '0);
    // entries older than the fill count were never written and read as zero
    pv      = dpc <= W'(fill_q);
    nv      = dnc <= W'(fill_q);
    np      = bpos_q + BLOCK_W'(1);

    wp_d        = wp_q;
    fill_d      = fill_q;
    bpos_d      = bpos_q;
    bits_done_d = bits_done_q;
    cur_bit_d   = cur_bit_q;
    fin_d       = fin_q;
    if (accept) begin
      cur_bit_d = bit_now;
      fin_d     = fin_now;
      if (!fin_now) begin
        if (np == sz) begin
          bpos_d = '0;
          if (hdr) begin
            bits_done_d = bits_done_q + BD_W'(1);
          end
        end else begin
          bpos_d = np;
        end
      end
      wp_d   = (wp_q == AW'(DELAY_DEPTH - 1)) ? '0 : wp_q + AW'(1);
      fill_d = (fill_q == CNT_W'(DELAY_DEPTH)) ? fill_q : fill_q + CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q        <= '0;
      fill_q      <= '0;
      bpos_q      <= '0;
      bits_done_q <= '0;
      cur_bit_q   <= 1'b0;
      fin_q       <= 1'b0;
      s1_valid_q  <= 1'b0;
    end else begin
      wp_q        <= wp_d;
      fill_q      <= fill_d;
      bpos_q      <= bpos_d;
      bits_done_q <= bits_done_d;
      cur_bit_q   <= cur_bit_d;
      fin_q       <= fin_d;
      s1_valid_q  <= accept;
    end
  end

  // delay line, read before write at the same slot
  logic [SAMPLE_W-1:0] mem [DELAY_DEPTH];
  logic [SAMPLE_W-1:0] rd_p_q, rd_n_q;

  always_ff @(posedge clk_i) begin
    if (accept) begin
      mem[wp_q] <= sample_i;
    end
    rd_p_q <= mem[addr_p];
    rd_n_q <= mem[addr_n];
  end

  // read stage payload
  logic [SAMPLE_W-1:0] s1_sample_q;
  logic [GAIN_W-1:0]   s1_alpha_q;
  logic                s1_active_q, s1_pz_q, s1_pv_q, s1_nz_q, s1_nv_q;

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_sample_q <= sample_i;
      s1_alpha_q  <= alpha;
      s1_active_q <= !fin_now;
      s1_pz_q     <= pz;
      s1_pv_q     <= pv;
      s1_nz_q     <= nz;
      s1_nv_q     <= nv;
    end
  end

  always_comb begin
    item_o.sample = s1_sample_q;
    item_o.alpha  = s1_alpha_q;
    item_o.active = s1_active_q;
    item_o.tap_p  = s1_pz_q ? s1_sample_q : (s1_pv_q ? rd_p_q : '0);
    item_o.tap_n  = s1_nz_q ? s1_sample_q : (s1_nv_q ? rd_n_q : '0);
  end

  assign push_o = s1_valid_q;

endmodule

### src/ehe_queue.sv
// short first-in first-out queue between the front and back ends
// depends on ehe_pkg
module ehe_queue import ehe_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  ehe_item_t         item_i,
  input  logic              pop_i,
  output ehe_item_t         item_o,
  output logic [QLVL_W-1:0] level_o
);

  ehe_item_t          slots [QUEUE_DEPTH];
  logic [QPTR_W-1:0]  wr_q, rd_q;
  logic [QLVL_W-1:0]  lvl_q;

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slots[wr_q] <= item_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      lvl_q <= '0;
    end else begin
      if (push_i) begin
        wr_q <= wr_q + QPTR_W'(1);
      end
      if (pop_i) begin
        rd_q <= rd_q + QPTR_W'(1);
      end
      if (push_i && !pop_i) begin
        lvl_q <= lvl_q + QLVL_W'(1);
      end else if (pop_i && !push_i) begin
        lvl_q <= lvl_q - QLVL_W'(1);
      end
    end
  end

  assign item_o  = slots[rd_q];
  assign level_o = lvl_q;

endmodule

### src/ehe_back.sv
// back end: echo multiply, rounding toward zero, saturation, output register
// depends on ehe_pkg
module ehe_back import ehe_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                q_valid_i,
  input  ehe_item_t           item_i,
  output logic                pop_o,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic [SAMPLE_W-1:0] out_sample_o,
  output logic                embedding_o
);

  logic                m_valid_q;
  logic [SAMPLE_W-1:0] m_sample_q;
  logic                m_active_q;
  logic signed [32:0]  m_prod_q;

  logic                out_valid_q;
  logic [SAMPLE_W-1:0] out_sample_q;
  logic                embedding_q;

  logic                out_free, m_adv;
  logic signed [16:0]  diff;
  logic signed [32:0]  prod;
  logic signed [33:0]  t, adj, sh;
  logic [SAMPLE_W-1:0] y;

  assign out_free = !out_valid_q || !out_stall_i;
  assign m_adv    = !m_valid_q || out_free;
  assign pop_o    = q_valid_i && m_adv;

  assign diff = 17'($signed(item_i.tap_p)) - 17'($signed(item_i.tap_n));
  assign prod = 33'($signed({1'b0, item_i.alpha})) * 33'(diff);

  always_comb begin
    t   = 34'($signed({m_sample_q, 15'b0})) + 34'(m_prod_q);
    // bias negatives so the arithmetic shift truncates toward zero
    adj = t + (t[33] ? 34'sd32767 : 34'sd0);
    sh  = adj >>> 15;
    if (sh > 34'sd32767) begin
      y = 16'h7fff;
    end else if (sh < -34'sd32768) begin
      y = 16'h8000;
    end else begin
      y = sh[SAMPLE_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (m_adv) begin
        m_valid_q <= pop_o;
      end
      if (out_free) begin
        out_valid_q <= m_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      m_sample_q <= item_i.sample;
      m_active_q <= item_i.active;
      m_prod_q   <= prod;
    end
    if (m_valid_q && out_free) begin
      out_sample_q <= m_active_q ? y : m_sample_q;
      embedding_q  <= m_active_q;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign out_sample_o = out_sample_q;
  assign embedding_o  = embedding_q;

endmodule

### src/echo_hiding_embedder_top.sv
// echo hiding embedder: one audio sample in, one stego sample out
// Input words carry a sample plus a message bit and a more flag that are read
// only at a block start. A word is taken when in_valid_i is high and
// in_stall_o low; a result is taken when out_valid_o is high and out_stall_i
// low. Registers are written over the cfg channel, which is always ready; the
// user must write them only while the block is idle, which it does not enforce.
// Throughput is one sample per cycle while in_stall_o is low, set by the
// two-port delay line read once per word. From the accepting edge a word
// passes the delay line read stage, the queue, the multiply stage, then
// rounding and saturation into the output register that drives out_valid_o.
// When the receiver stalls, the result holds, the back end stops and the
// four-entry queue fills; in_stall_o rises once the queue and the read stage
// together hold four words.
// Reset restores register defaults and clears all control state. The delay
// line needs no clearing pass: a fill count makes slots not yet written read
// as zero, so words are taken from the first cycle after reset.
// Depends on ehe_pkg, ehe_front, ehe_queue, ehe_back
module echo_hiding_embedder_top import ehe_pkg::*; #(
  parameter int HDR_LEN     = HDR_LEN_DEF,
  parameter int DELAY_DEPTH = DELAY_DEPTH_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [CFG_DAT_W-1:0] cfg_data_i,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  logic [SAMPLE_W-1:0]  sample_i,
  input  logic                 message_bit_i,
  input  logic                 message_more_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output logic [SAMPLE_W-1:0]  out_sample_o,
  output logic                 embedding_o
);

  logic              q_push, q_pop;
  ehe_item_t         q_in, q_out;
  logic [QLVL_W-1:0] q_level;

  assign cfg_ready_o = 1'b1;

  ehe_front #(
    .HDR_LEN(HDR_LEN),
    .DELAY_DEPTH(DELAY_DEPTH)
  ) u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_valid_i    (cfg_valid_i && cfg_ready_o),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .in_valid_i     (in_valid_i),
    .sample_i       (sample_i),
    .message_bit_i  (message_bit_i),
    .message_more_i (message_more_i),
    .in_stall_o     (in_stall_o),
    .q_level_i      (q_level),
    .push_o         (q_push),
    .item_o         (q_in)
  );

  ehe_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .item_i  (q_in),
    .pop_i   (q_pop),
    .item_o  (q_out),
    .level_o (q_level)
  );

  ehe_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .q_valid_i    (q_level != '0),
    .item_i       (q_out),
    .pop_o        (q_pop),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .out_sample_o (out_sample_o),
    .embedding_o  (embedding_o)
  );

  // an accepted word raises the queue push from the next edge
  a_accept_pushes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> q_push)
    else $error("accepted word did not reach the queue");

  // the stall threshold must keep a slot free for the read stage
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_push |-> (q_level < QLVL_W'(QUEUE_DEPTH)))
    else $error("queue written while full");

  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop |-> (q_level != '0))
    else $error("queue read while empty");

endmodule
